// ----- rtl/gsc_dbe_pkg.sv -----
package gsc_dbe_pkg;

  typedef logic [5:0] sym_t;
  typedef sym_t [11:0] sym_vec_t;
  typedef logic [14:0] cw_t;
  typedef cw_t [7:0] cw_set_t;

  localparam logic [8:0] BCH_GEN   = 9'h117;
  localparam sym_t       ALPHA_PAD = 6'h3e;
  localparam logic [3:0] NUM_PAD   = 4'ha;
  localparam logic [3:0] EXT_DIGIT = 4'hf;
  localparam sym_t       NEWLINE_CODE = 6'h3c;
  localparam sym_t       LBRACE_CODE  = 6'h3b;
  localparam sym_t       RBRACE_CODE  = 6'h3d;
  localparam logic [3:0] ALPHA_LAST_POS = 4'd7;
  localparam logic [3:0] NUM_LAST_POS   = 4'd11;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERIC_LIMIT = 1'b1;

  localparam logic [7:0] ALPHA_LIMIT_RST   = 8'd10;
  localparam logic [7:0] NUMERIC_LIMIT_RST = 8'd2;

  // Systematic BCH(15,7) codeword: data in the low seven bits, parity above.
  function automatic cw_t bch_word(logic [6:0] d);
    logic [14:0] r;
    begin
      r = {d, 8'h00};
      for (int b = 14; b >= 8; b--) begin
        if (r[b]) begin
          r = r ^ (15'({6'h00, BCH_GEN}) << (b - 8));
        end
      end
      return {r[7:0], d};
    end
  endfunction

  function automatic sym_t alpha_code(logic [7:0] c);
    logic [7:0] u;
    sym_t       code;
    begin
      u = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
        u = c - 8'h20;
      end
      case (u) inside
        8'h0a, 8'h0d: code = NEWLINE_CODE;
        8'h7b:        code = LBRACE_CODE;
        8'h7d:        code = RBRACE_CODE;
        8'h5c:        code = '0;
        [8'h20:8'h5b], 8'h5d: code = 6'(u - 8'h20);
        default:      code = '0;
      endcase
      return code;
    end
  endfunction

  // Bit 4 set marks an extended letter: 0xf digit first, then the low digit.
  function automatic logic [4:0] numeric_code(logic [7:0] c);
    logic [7:0] u;
    logic [4:0] d;
    begin
      u = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
        u = c - 8'h20;
      end
      case (u) inside
        [8'h30:8'h39]: d = 5'(u - 8'h30);
        8'h55:         d = 5'h0b;
        8'h20:         d = 5'h0c;
        8'h2d:         d = 5'h0d;
        8'h3d, 8'h2a:  d = 5'h0e;
        8'h41:         d = 5'h10;
        8'h42:         d = 5'h11;
        8'h43:         d = 5'h12;
        8'h44:         d = 5'h13;
        8'h45:         d = 5'h14;
        8'h46:         d = 5'h16;
        8'h47:         d = 5'h17;
        8'h48:         d = 5'h18;
        8'h4a:         d = 5'h19;
        8'h4c:         d = 5'h1b;
        8'h4e:         d = 5'h1c;
        8'h50:         d = 5'h1d;
        8'h52:         d = 5'h1e;
        default:       d = 5'h0c;
      endcase
      return d;
    end
  endfunction

  // Packs one block of symbols into seven data words plus the checksum word.
  function automatic cw_set_t encode_block(sym_vec_t m, logic numeric, logic cont);
    logic [6:0] d [8];
    logic [3:0] n [12];
    logic [6:0] sum7;
    cw_set_t    w;
    begin
      for (int i = 0; i < 12; i++) begin
        n[i] = m[i][3:0];
      end
      if (!numeric) begin
        d[0] = {m[1][0],   m[0]};
        d[1] = {m[2][1:0], m[1][5:1]};
        d[2] = {m[3][2:0], m[2][5:2]};
        d[3] = {m[4][3:0], m[3][5:3]};
        d[4] = {m[5][4:0], m[4][5:4]};
        d[5] = {m[6],      m[5][5]};
        d[6] = {cont,      m[7]};
      end else begin
        d[0] = {n[1][2:0],  n[0]};
        d[1] = {n[3][1:0],  n[2], n[1][3]};
        d[2] = {n[5][0],    n[4], n[3][3:2]};
        d[3] = {n[6],       n[5][3:1]};
        d[4] = {n[8][2:0],  n[7]};
        d[5] = {n[10][1:0], n[9], n[8][3]};
        d[6] = {cont,       n[11], n[10][3:2]};
      end
      // The low seven bits of the codeword sum depend only on the data bits.
      sum7 = d[0] + d[1] + d[2] + d[3] + d[4] + d[5] + d[6];
      d[7] = sum7;
      for (int k = 0; k < 8; k++) begin
        w[k] = bch_word(d[k]);
      end
      return w;
    end
  endfunction

endpackage

// ----- rtl/gsc_data_block_encoder.sv -----
// A block's comma item passes from the input register through the block registers to m_tdata.
// Throughput: characters that close no block are taken every cycle, also while a block leaves,
// unless a closing character waits in the input register; a block is a comma plus 15 columns,
// and the next closing character is processed at the edge that loads the last column.
// A closing extended numeric letter can emit two blocks, 32 items, in one run.
// Reset (rst, synchronous, active high) clears all control state and sets the limits to 10 and 2.
module gsc_data_block_encoder (
  input  logic       clk,
  input  logic       rst,
  // Character input.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // final_char
  input  logic       s_tuser,   // numeric_mode
  // Block output.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] column_bits
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser,   // is_comma
  // Register writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gsc_dbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import gsc_dbe_pkg::*;

  // Block limits for the continue bit.
  logic [7:0] alpha_limit;
  logic [7:0] numeric_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_limit   <= ALPHA_LIMIT_RST;
      numeric_limit <= NUMERIC_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA_LIMIT:   alpha_limit   <= cfg_data;
        CFG_NUMERIC_LIMIT: numeric_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. A character that closes a block waits here until the
  // emitter is free or is loading the last column of its final block.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_fin;
  logic       in_mode;
  logic       proc_fire;
  logic       busy;
  logic       emit_done;
  logic       fire_a;

  assign proc_fire = in_valid && (!busy || !fire_a || emit_done);
  assign s_tready  = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_fin  <= s_tlast;
      in_mode <= s_tuser;
    end
  end

  // Message state.
  sym_vec_t   store;
  logic [3:0] fill_count;
  logic [7:0] block_index;
  logic       latched_mode;
  logic       in_message;

  // Character processing: place the new symbols, decide which blocks close.
  logic       mode;
  logic [3:0] fill0;
  logic [7:0] bidx0;
  sym_t       acode;
  logic [4:0] ncode;
  logic       ext;
  sym_t       s0;
  sym_t       low;
  sym_t       pad;
  sym_vec_t   vec_a;
  sym_vec_t   vec_b;
  logic       full;
  logic       wrap;
  logic       fire_b;
  logic       cont_a;
  logic [7:0] limit;
  logic [3:0] fill_next;
  logic [7:0] bidx_next;

  always_comb begin
    mode   = in_message ? latched_mode : in_mode;
    fill0  = in_message ? fill_count : 4'd0;
    bidx0  = in_message ? block_index : 8'd0;
    acode  = alpha_code(in_char);
    ncode  = numeric_code(in_char);
    ext    = mode && ncode[4];
    low    = {2'b00, ncode[3:0]};
    s0     = !mode ? acode : (ext ? {2'b00, EXT_DIGIT} : low);
    pad    = mode ? {2'b00, NUM_PAD} : ALPHA_PAD;

    for (int i = 0; i < 12; i++) begin
      if (4'(i) < fill0) begin
        vec_a[i] = store[i];
      end else if (4'(i) == fill0) begin
        vec_a[i] = s0;
      end else if (ext && 4'(i) == fill0 + 4'd1) begin
        vec_a[i] = low;
      end else begin
        vec_a[i] = pad;
      end
      // Second block of a split letter: its low digit, then numeric padding.
      vec_b[i] = (i == 0) ? low : {2'b00, NUM_PAD};
    end

    if (!mode) begin
      full = (fill0 == ALPHA_LAST_POS);
    end else if (ext) begin
      full = (fill0 == NUM_LAST_POS - 4'd1);
    end else begin
      full = (fill0 == NUM_LAST_POS);
    end
    // An extended letter whose 0xf digit fills the block: its low digit opens the next one.
    wrap   = ext && (fill0 == NUM_LAST_POS);
    fire_a = wrap || full || in_fin;
    fire_b = wrap && in_fin;
    limit  = mode ? numeric_limit : alpha_limit;
    cont_a = (wrap || !in_fin) && (bidx0 < limit);

    if (in_fin) begin
      fill_next = 4'd0;
    end else if (wrap) begin
      fill_next = 4'd1;
    end else if (fire_a) begin
      fill_next = 4'd0;
    end else begin
      fill_next = fill0 + (ext ? 4'd2 : 4'd1);
    end

    bidx_next = bidx0;
    if (fire_a && bidx_next != 8'hff) begin
      bidx_next = bidx_next + 8'd1;
    end
    if (fire_b && bidx_next != 8'hff) begin
      bidx_next = bidx_next + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= 4'd0;
      block_index  <= 8'd0;
      latched_mode <= 1'b0;
      in_message   <= 1'b0;
    end else if (proc_fire) begin
      fill_count   <= fill_next;
      block_index  <= bidx_next;
      latched_mode <= mode;
      in_message   <= !in_fin;
    end
  end

  // Entries past the fill point carry padding that is overwritten before any read.
  always_ff @(posedge clk) begin
    if (proc_fire) begin
      store <= wrap ? vec_b : vec_a;
    end
  end

  // Block emitter: holds up to two closed blocks and walks comma plus 15 columns each.
  sym_vec_t   blk_vec0;
  sym_vec_t   blk_vec1;
  logic       blk_cont0;
  logic       blk_mode;
  logic       two_blk;
  logic       blk_sel;
  logic [3:0] col;
  logic       load;
  cw_set_t    words;
  logic [3:0] bit_sel;
  logic [7:0] col_bits;
  logic       last_col;

  assign load      = busy && (!m_tvalid || m_tready);
  assign last_col  = (col == 4'd15);
  assign emit_done = load && last_col && (blk_sel || !two_blk);

  always_comb begin
    words   = encode_block(blk_sel ? blk_vec1 : blk_vec0, blk_mode,
                           blk_sel ? 1'b0 : blk_cont0);
    bit_sel = col - 4'd1;
    for (int k = 0; k < 8; k++) begin
      col_bits[k] = words[k][bit_sel];
    end
    if (col == 4'd0) begin
      col_bits = {7'b0000000, ~words[0][0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      blk_sel <= 1'b0;
      col     <= 4'd0;
    end else if (proc_fire && fire_a) begin
      busy    <= 1'b1;
      blk_sel <= 1'b0;
      col     <= 4'd0;
    end else if (load) begin
      if (last_col) begin
        col <= 4'd0;
        if (!blk_sel && two_blk) begin
          blk_sel <= 1'b1;
        end else begin
          busy <= 1'b0;
        end
      end else begin
        col <= col + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && fire_a) begin
      blk_vec0  <= vec_a;
      blk_vec1  <= vec_b;
      blk_cont0 <= cont_a;
      blk_mode  <= mode;
      two_blk   <= fire_b;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= col_bits;
      m_tuser <= (col == 4'd0);
      m_tlast <= last_col && (blk_sel || !two_blk);
    end
  end

`ifndef SYNTHESIS
  a_alpha_fill: assert property (@(posedge clk) disable iff (rst)
    in_message && !latched_mode |-> fill_count < 4'd8)
    else $error("alpha fill count out of range");
  a_idle_fill: assert property (@(posedge clk) disable iff (rst)
    !in_message |-> fill_count == 4'd0)
    else $error("fill count not cleared between messages");
  a_two_numeric: assert property (@(posedge clk) disable iff (rst)
    busy && two_blk |-> blk_mode)
    else $error("two blocks from one alpha character");
  a_last_not_comma: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("run ends on a comma item");
  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");
`endif

endmodule

// ----- verif/gsc_data_block_encoder_tb.sv -----
`timescale 1ns / 100ps

module gsc_data_block_encoder_tb;

  // Symbol and digit codes the encoder uses for special characters and padding.
  localparam logic [5:0] SYM_BLANK  = 6'h00;
  localparam logic [5:0] SYM_EOL    = 6'h3c;
  localparam logic [5:0] SYM_LBR    = 6'h3b;
  localparam logic [5:0] SYM_RBR    = 6'h3d;
  localparam logic [5:0] SYM_FILL   = 6'h3e;
  localparam logic [3:0] DIGIT_FILL  = 4'ha;
  localparam logic [3:0] DIGIT_ESC   = 4'hf;
  localparam logic [3:0] DIGIT_BLANK = 4'hc;
  localparam logic [7:0] LOW_GEN     = 8'h17;  // generator 0x117 without its x^8 term

  localparam int ALPHA_SYMS = 8;
  localparam int NUM_DIGITS = 12;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] col_bits;
    logic       comma;
    logic       run_end;
  } block_item_t;

  typedef struct {
    logic [7:0] code;
    logic       fin;
    logic       mode;
    int         n_items;
  } char_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       s_tuser  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [gsc_dbe_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [7:0]                            cfg_data  = 8'h00;

  always #6 clk = ~clk;

  gsc_data_block_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Encoder state as the testbench tracks it, updated on every accepted character.
  logic [5:0] sym_mem [NUM_DIGITS];
  logic [3:0] fill_cnt = 4'd0;
  logic [7:0] blk_idx  = 8'd0;
  logic [7:0] alpha_lim = 8'd10;
  logic [7:0] num_lim   = 8'd2;
  logic       num_mode = 1'b0;
  logic       msg_open = 1'b0;

  // Block items the encoder still owes, oldest first.
  block_item_t block_items_q [$];

  int  mismatches = 0;
  int  tx_sent = 0;
  logic tx_fast = 1'b0;
  logic hold_request = 1'b0;
  string digit_pool = "0123456789U -=*ABCDEFGHJLNPRabcdefghjlnpr";

  // Directed characters. The item count of each row follows directly from how
  // many symbols are buffered: a full block or a closing character gives 16
  // items, a split letter that closes a full block on the last character 32.
  char_row_t char_rows [22] = '{
    '{8'h61, 1'b0, 1'b0, 0},   // lowercase folds to uppercase
    '{8'h7b, 1'b0, 1'b0, 0},   // left brace
    '{8'h7d, 1'b0, 1'b0, 0},   // right brace
    '{8'h5c, 1'b0, 1'b0, 0},   // backslash maps to blank
    '{8'h0a, 1'b0, 1'b0, 0},   // line feed
    '{8'hff, 1'b0, 1'b0, 0},   // top byte, no code
    '{8'h5d, 1'b0, 1'b0, 0},   // highest direct code
    '{8'h0d, 1'b0, 1'b0, 16},  // carriage return fills the block
    '{8'h20, 1'b1, 1'b0, 16},  // lone closing space, padded block
    '{8'h30, 1'b0, 1'b1, 0},   // numeric message opens
    '{8'h39, 1'b0, 1'b0, 0},   // mode bit ignored after the first character
    '{8'h55, 1'b0, 1'b1, 0},
    '{8'h20, 1'b0, 1'b1, 0},
    '{8'h2d, 1'b0, 1'b1, 0},
    '{8'h3d, 1'b0, 1'b1, 0},
    '{8'h2a, 1'b0, 1'b1, 0},
    '{8'h61, 1'b0, 1'b1, 0},   // lowercase extended letter, two digits
    '{8'h35, 1'b0, 1'b1, 0},
    '{8'h51, 1'b0, 1'b1, 0},   // letter without a digit code
    '{8'h72, 1'b1, 1'b1, 32},  // split letter at block end on the last character
    '{8'h41, 1'b1, 1'b1, 16},  // one-letter numeric message
    '{8'h00, 1'b1, 1'b0, 16}   // lowest byte as a one-character message
  };

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // Systematic BCH(15,7) word: a serial divider forms the 8 parity bits.
  function automatic logic [14:0] bch15(logic [6:0] d);
    logic [7:0] par;
    logic       fb;
    par = 8'h00;
    for (int i = 6; i >= 0; i--) begin
      fb = d[i] ^ par[7];
      par = {par[6:0], 1'b0};
      if (fb) begin
        par = par ^ LOW_GEN;
      end
    end
    return {par, d};
  endfunction

  function automatic logic [5:0] alpha_sym(logic [7:0] c);
    logic [7:0] u;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
    if (u == 8'h0a || u == 8'h0d) return SYM_EOL;
    if (u == 8'h7b) return SYM_LBR;
    if (u == 8'h7d) return SYM_RBR;
    if (u == 8'h5c || u < 8'h20 || u > 8'h5d) return SYM_BLANK;
    return 6'(u - 8'h20);
  endfunction

  // Bit 4 flags an extended letter that is sent as an escape digit plus bits 3:0.
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [7:0] u;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
    if (u >= 8'h30 && u <= 8'h39) return 5'(u - 8'h30);
    case (u)
      8'h55:        return 5'h0b;  // U
      8'h2d:        return 5'h0d;  // -
      8'h3d, 8'h2a: return 5'h0e;  // = *
      8'h41:        return 5'h10;
      8'h42:        return 5'h11;
      8'h43:        return 5'h12;
      8'h44:        return 5'h13;
      8'h45:        return 5'h14;
      8'h46:        return 5'h16;
      8'h47:        return 5'h17;
      8'h48:        return 5'h18;
      8'h4a:        return 5'h19;
      8'h4c:        return 5'h1b;
      8'h4e:        return 5'h1c;
      8'h50:        return 5'h1d;
      8'h52:        return 5'h1e;
      default:      return {1'b0, DIGIT_BLANK};  // space and anything unknown
    endcase
  endfunction

  function automatic void store_sym(logic [5:0] v);
    if (fill_cnt < 4'(NUM_DIGITS)) begin
      sym_mem[fill_cnt] = v;
    end
    fill_cnt = fill_cnt + 4'd1;
  endfunction

  // Forms the eight codewords of the buffered block and queues its comma and
  // 15 column items.
  function automatic void emit_block(logic more);
    logic [6:0]  dw [8];
    logic [14:0] cw [8];
    logic [41:0] abits;
    logic [27:0] nlo;
    logic [19:0] nhi;
    logic [15:0] acc;
    logic [7:0]  col;
    logic        cont;
    block_item_t item;
    cont = more && (blk_idx < (num_mode ? num_lim : alpha_lim));
    if (!num_mode) begin
      // Seven 6-bit symbols run as one bit stream through words 0..5.
      abits = {sym_mem[6], sym_mem[5], sym_mem[4], sym_mem[3],
               sym_mem[2], sym_mem[1], sym_mem[0]};
      for (int i = 0; i < 6; i++) begin
        dw[i] = abits[7*i +: 7];
      end
      dw[6] = {cont, sym_mem[7]};
    end else begin
      // Digits 0..6 fill words 0..3, digits 7..11 words 4..6.
      nlo = {sym_mem[6][3:0], sym_mem[5][3:0], sym_mem[4][3:0], sym_mem[3][3:0],
             sym_mem[2][3:0], sym_mem[1][3:0], sym_mem[0][3:0]};
      nhi = {sym_mem[11][3:0], sym_mem[10][3:0], sym_mem[9][3:0],
             sym_mem[8][3:0], sym_mem[7][3:0]};
      for (int i = 0; i < 4; i++) begin
        dw[i] = nlo[7*i +: 7];
      end
      dw[4] = nhi[6:0];
      dw[5] = nhi[13:7];
      dw[6] = {cont, nhi[19:14]};
    end
    acc = 16'd0;
    for (int i = 0; i < 7; i++) begin
      cw[i] = bch15(dw[i]);
      acc = acc + 16'(cw[i]);
    end
    cw[7] = bch15(acc[6:0]);
    item.col_bits = {7'd0, ~cw[0][0]};
    item.comma = 1'b1;
    item.run_end = 1'b0;
    block_items_q.push_back(item);
    for (int j = 0; j < 15; j++) begin
      for (int k = 0; k < 8; k++) begin
        col[k] = cw[k][j];
      end
      item.col_bits = col;
      item.comma = 1'b0;
      block_items_q.push_back(item);
    end
    if (blk_idx != 8'hff) begin
      blk_idx = blk_idx + 8'd1;
    end
    fill_cnt = 4'd0;
  endfunction

  // Advances the tracked state by one character and returns how many items it owes.
  function automatic int encode_char(logic [7:0] c, logic fin, logic mode_in);
    int         start;
    logic [4:0] nd;
    start = block_items_q.size();
    if (!msg_open) begin
      num_mode = mode_in;
      msg_open = 1'b1;
      blk_idx = 8'd0;
      fill_cnt = 4'd0;
    end
    if (!num_mode) begin
      store_sym(alpha_sym(c));
      if (fill_cnt == 4'(ALPHA_SYMS)) emit_block(!fin);
      if (fin && fill_cnt != 4'd0) begin
        while (fill_cnt < 4'(ALPHA_SYMS)) store_sym(SYM_FILL);
        emit_block(1'b0);
      end
    end else begin
      nd = digit_of(c);
      if (nd[4]) begin
        // The escape digit may close a block; the low digit then opens the next.
        store_sym({2'b00, DIGIT_ESC});
        if (fill_cnt == 4'(NUM_DIGITS)) emit_block(1'b1);
      end
      store_sym({2'b00, nd[3:0]});
      if (fill_cnt == 4'(NUM_DIGITS)) emit_block(!fin);
      if (fin && fill_cnt != 4'd0) begin
        while (fill_cnt < 4'(NUM_DIGITS)) store_sym({2'b00, DIGIT_FILL});
        emit_block(1'b0);
      end
    end
    if (fin) begin
      msg_open = 1'b0;
      fill_cnt = 4'd0;
    end
    if (block_items_q.size() > start) begin
      block_items_q[block_items_q.size()-1].run_end = 1'b1;
    end
    return block_items_q.size() - start;
  endfunction

  // Offers one character after a random gap and returns once it is taken.
  task automatic send_char(input logic [7:0] c, input logic fin, input logic mode_in,
                           output int n_out);
    int gap;
    if (tx_sent % 24 == 0) tx_fast = ($urandom_range(0, 2) == 0);
    gap = tx_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    s_tuser  <= mode_in;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    n_out = encode_char(c, fin, mode_in);
    tx_sent++;
    // Mid-run, ask the receiver to hold off while characters keep coming.
    if (tx_sent == 150) hold_request = 1'b1;
  endtask

  // One message of random length and content; mostly valid characters for its
  // mode, with some arbitrary bytes and a random mode bit after the first.
  task automatic send_message(input logic mode_in, output int n_chars);
    int         len;
    int         n;
    logic [7:0] c;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        c = 8'($urandom_range(0, 255));
      end else if (mode_in) begin
        c = digit_pool[$urandom_range(0, digit_pool.len() - 1)];
      end else if ($urandom_range(0, 3) == 0) begin
        c = 8'($urandom_range(8'h61, 8'h7a));
      end else begin
        c = 8'($urandom_range(8'h20, 8'h5d));
      end
      send_char(c, (i == len - 1), (i == 0) ? mode_in : 1'($urandom_range(0, 1)), n);
    end
    n_chars = len;
  endtask

  task automatic write_limit(input logic [gsc_dbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      gsc_dbe_pkg::CFG_ALPHA_LIMIT:   alpha_lim = val;
      gsc_dbe_pkg::CFG_NUMERIC_LIMIT: num_lim   = val;
      default: ;
    endcase
  endtask

  // Stops offering characters until every owed item is out, then lets the
  // pipeline settle.
  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (block_items_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random backpressure, one long hold when asked, and a check of
  // every accepted item against the oldest owed one.
  initial begin : rx_side
    int          gap;
    int          rx_count;
    logic        rx_fast;
    logic [7:0]  got_col;
    logic        got_comma;
    logic        got_end;
    block_item_t want;
    rx_count = 0;
    rx_fast = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (rx_count % 24 == 0) rx_fast = ($urandom_range(0, 2) == 0);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_fast ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      got_col   = m_tdata;
      got_comma = m_tuser;
      got_end   = m_tlast;
      @(posedge clk);
      rx_count++;
      if (block_items_q.size() == 0) begin
        log_mismatch($sformatf("item %02h comma %b last %b with nothing owed",
                               got_col, got_comma, got_end));
      end else begin
        want = block_items_q.pop_front();
        if (got_col !== want.col_bits)
          log_mismatch($sformatf("item %0d column %02h, want %02h",
                                 rx_count, got_col, want.col_bits));
        if (got_comma !== want.comma)
          log_mismatch($sformatf("item %0d comma flag %b, want %b",
                                 rx_count, got_comma, want.comma));
        if (got_end !== want.run_end)
          log_mismatch($sformatf("item %0d last flag %b, want %b",
                                 rx_count, got_end, want.run_end));
      end
    end
  end

  // Main sequence: reset, directed characters at the reset limits, then random
  // messages under several limit settings, 1 and 255 among them.
  initial begin : tx_side
    int         n;
    int         sent;
    logic [7:0] a_set [4];
    logic [7:0] n_set [4];
    for (int i = 0; i < NUM_DIGITS; i++) sym_mem[i] = 6'h00;
    a_set = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 6))};
    n_set = '{8'd255, 8'd1, 8'd4, 8'($urandom_range(1, 6))};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (char_rows[i]) begin
      send_char(char_rows[i].code, char_rows[i].fin, char_rows[i].mode, n);
      if (n != char_rows[i].n_items)
        log_mismatch($sformatf("directed row %0d owes %0d items, table lists %0d",
                               i, n, char_rows[i].n_items));
    end
    drain_and_settle();

    for (int p = 0; p < 4; p++) begin
      write_limit(gsc_dbe_pkg::CFG_ALPHA_LIMIT, a_set[p]);
      write_limit(gsc_dbe_pkg::CFG_NUMERIC_LIMIT, n_set[p]);
      cfg_valid <= 1'b0;
      sent = 0;
      while (sent < 87) begin
        send_message(1'($urandom_range(0, 1)), n);
        sent += n;
      end
      drain_and_settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gsc_dbe_pkg.sv
rtl/gsc_data_block_encoder.sv
verif/gsc_data_block_encoder_tb.sv
